// ----- design/cts_pkg.sv -----
// ----------------------------------------------------------------------------
// cts_pkg: shared types and helpers for the CDF table sampler
// Request and response payloads, pipeline stage record, bisection step.
// ----------------------------------------------------------------------------
package cts_pkg;

  localparam int TABLE_DEPTH_DEF = 65536;
  localparam logic [15:0] ENTRY_COUNT_RST = 16'hFFFF;
  localparam int BOUND_W = 17;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_DRAW = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [15:0] entry_index;
    logic [31:0] cdf_value;
    logic [31:0] random_value;
  } req_t;

  typedef struct packed {
    logic [15:0] sample_index;
    logic        found;
  } rsp_t;

  typedef struct packed {
    logic               kind;
    logic [15:0]        idx;
    logic [31:0]        val;
    logic [31:0]        draw;
    logic [15:0]        n;
    logic [BOUND_W-1:0] lo;
    logic [BOUND_W-1:0] hi;
  } stage_t;

  function automatic logic [BOUND_W-1:0] mid_of(input logic [BOUND_W-1:0] lo,
                                                input logic [BOUND_W-1:0] hi);
    logic [BOUND_W-1:0] span;
    span = hi - lo;
    return lo + (span >> 1);
  endfunction

  function automatic stage_t step_update(input stage_t s, input logic [31:0] d);
    stage_t             r;
    logic [BOUND_W-1:0] mid;
    r   = s;
    mid = mid_of(s.lo, s.hi);
    if (s.lo < s.hi) begin
      if (d >= s.draw) begin
        r.hi = mid;
      end else begin
        r.lo = mid + BOUND_W'(1);
      end
    end
    return r;
  endfunction

endpackage

// ----- design/cdf_table_sampler.sv -----
// ----------------------------------------------------------------------------
// cdf_table_sampler: pipelined inverse-CDF sampler over a loaded table
// Binary search over cumulative Q0.32 entries, one bisection level per stage.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (valid/ready) carries load requests (write one table entry)
//   and draw requests (search the table for a random fraction).
//   rsp channel (valid/ready) returns one result per draw; loads give none.
//   cfg_we/cfg_wdata write entry_count; write only while the block is idle.
// Pipeline:
//   STEPS = clog2(min(65535, TABLE_DEPTH-1) + 1) stages, 16 at the default
//   depth. Each stage owns a copy of the table with one read port; a draw
//   passes them all, then the rsp register. One request per cycle unless
//   rsp stalls. Loads travel the same stages and write each copy in turn,
//   so every draw sees exactly the loads accepted before it.
// Reset: clears all valid bits and sets entry_count to 65535; the table
//   holds whatever it held and must be loaded before use.
// Stall: while rsp is valid and not taken, the whole pipeline holds and
//   req_ready is low; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module cdf_table_sampler #(
  parameter int TABLE_DEPTH = cts_pkg::TABLE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [15:0]   cfg_wdata,
  input  logic          req_valid,
  output logic          req_ready,
  input  cts_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output cts_pkg::rsp_t rsp
);
  import cts_pkg::*;

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int MAX_N  = (TABLE_DEPTH - 1 < 65535) ? TABLE_DEPTH - 1 : 65535;
  localparam int STEPS  = $clog2(MAX_N + 1);

  logic [15:0] entry_count;
  logic [15:0] count_min;
  logic [15:0] count_eff;
  logic        en;

  stage_t      stg        [STEPS];
  stage_t      stg_next   [STEPS];
  logic        stg_valid  [STEPS];
  logic        stg_valid_next [STEPS];
  logic [31:0] rd         [STEPS];

  stage_t      last;
  logic        last_found;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= ENTRY_COUNT_RST;
    end else if (cfg_we) begin
      entry_count <= cfg_wdata;
    end
  end

  always_comb begin
    count_min = (entry_count == 16'd0) ? 16'd1 : entry_count;
    count_eff = (32'(count_min) > 32'(MAX_N)) ? 16'(MAX_N) : count_min;
  end

  assign en        = !rsp_valid || rsp_ready;
  assign req_ready = en;

  for (genvar k = 0; k < STEPS; k++) begin : g_stage
    logic [31:0]        mem [TABLE_DEPTH];
    logic [BOUND_W-1:0] mid;
    logic               wr_hit;

    if (k == 0) begin : g_entry
      always_comb begin
        stg_next[k].kind = req.req_type;
        stg_next[k].idx  = req.entry_index;
        stg_next[k].val  = req.cdf_value;
        stg_next[k].draw = req.random_value;
        stg_next[k].n    = count_eff;
        stg_next[k].lo   = BOUND_W'(1);
        stg_next[k].hi   = BOUND_W'(count_eff) + BOUND_W'(1);
        stg_valid_next[k] = req_valid;
      end
    end else begin : g_step
      always_comb begin
        stg_next[k]       = step_update(stg[k-1], rd[k-1]);
        stg_valid_next[k] = stg_valid[k-1];
      end
    end

    always_comb begin
      mid    = mid_of(stg_next[k].lo, stg_next[k].hi);
      wr_hit = stg_valid_next[k] && (stg_next[k].kind == REQ_LOAD) &&
               (32'(stg_next[k].idx) < 32'(TABLE_DEPTH));
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        stg_valid[k] <= 1'b0;
      end else if (en) begin
        stg_valid[k] <= stg_valid_next[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stg[k] <= stg_next[k];
        if (wr_hit) begin
          mem[ADDR_W'(stg_next[k].idx)] <= stg_next[k].val;
        end
        rd[k] <= mem[ADDR_W'(mid)];
      end
    end
  end

  always_comb begin
    last       = step_update(stg[STEPS-1], rd[STEPS-1]);
    last_found = last.lo <= BOUND_W'(last.n);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (en) begin
      rsp_valid <= stg_valid[STEPS-1] && (stg[STEPS-1].kind == REQ_DRAW);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp.found        <= last_found;
      rsp.sample_index <= last_found ? last.lo[15:0] : last.n;
    end
  end

endmodule

// ----- design/cts_checker.sv -----
// ----------------------------------------------------------------------------
// cts_checker: port-level checks for the CDF table sampler
// Response hold under stall, stall back-pressure, reset and index range.
// ----------------------------------------------------------------------------
module cts_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_ready,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input cts_pkg::rsp_t rsp
);
  import cts_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp))
    else $error("response changed while stalled");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |-> !req_ready)
    else $error("request taken while response stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

  a_index_nonzero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.sample_index != 16'd0)
    else $error("sample index zero");

endmodule

bind cdf_table_sampler cts_checker u_cts_checker (
  .clk       (clk),
  .rst       (rst),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
